// ----- design/rem_pkg.sv -----
// shared types, constants and the 2^-x table of the replica exchange block
// no dependencies
package rem_pkg;

  localparam int unsigned MAX_REPLICAS_DEF = 64;
  localparam int unsigned RES_LIMIT        = 64;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned RT_W             = 40;
  localparam int unsigned INV_W            = 62;
  localparam int unsigned DMAG_W           = 33;
  localparam int unsigned ACC_W            = 47;
  localparam int unsigned FIFO_DEPTH       = 4;

  localparam logic [INV_W-1:0] INV_NUM     = 62'd1000 << 52;
  localparam logic [ACC_W-1:0] DELTA_LIMIT = 47'd32 << 40;
  localparam logic [16:0]      LOG2E_Q16   = 17'd94548;
  localparam logic [6:0]       EXP_N_MAX   = 7'd17;
  localparam logic [1:0]       KIND_VALID  = 2'd1;

  localparam logic [6:0]  RC_RESET  = 7'd2;
  localparam logic [23:0] GAS_RESET = 24'd8717697;

  typedef enum logic [1:0] {
    CFG_REPLICA_COUNT = 2'd0,
    CFG_GAS_CONSTANT  = 2'd1,
    CFG_PAIRING_KIND  = 2'd2,
    CFG_SAMPLING_KIND = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0]  replica_count;
    logic [23:0] gas_constant_q;
    logic [1:0]  pairing_kind;
    logic [1:0]  sampling_kind;
  } cfg_t;

  typedef struct packed {
    logic               perm_wr;
    logic               in_range;
    logic               round;
    logic [5:0]         idx;
    logic [15:0]        param;
    logic signed [31:0] energy;
    logic [15:0]        temp;
    logic [15:0]        rnd;
    logic               parity;
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_ROUND_GO, S_PAIR_RD, S_MUL,
    S_DIVA_GO, S_DIVA_WAIT, S_DIVB_GO, S_DIVB_WAIT, S_DELTA, S_SMUL,
    S_EXP1, S_EXP2, S_EXP3, S_SWAP_A, S_SWAP_B, S_NEXT, S_EMIT_RD, S_EMIT_WR
  } back_state_t;

  // round(65536 * 2^(-k/16))
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55110;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/replica_exchange_metropolis_top.sv -----
// replica exchange round with metropolis acceptance: top level
// holds the configuration registers; depends on rem_pkg, rem_front, rem_back
//
// input channel (in_valid/in_ready): op 0 writes a permutation entry, op 1 loads
// one replica sample; a sample with in_last set starts an exchange round.
// words enter a four-deep command queue, so loading runs at one word per cycle
// while the back end is idle.
// a round walks n replicas (replica_count clamped to 2..64): a temperature scan,
// then per neighbour pair two serial divisions for 1000/(R*T) and a shift-add
// for the exponent, then the emission of each entry.
// output channel (out_valid/out_ready): n words, out_last on the final one;
// a stalled receiver holds the output register and the emission waits, while
// the queue keeps accepting words until full. the user writes configuration
// (cfg_we/cfg_index/cfg_wdata) while idle; the block does not enforce it.
// reset: synchronous, active low; permutation table returns to identity,
// queue and output empty, registers to their reset values.
module replica_exchange_metropolis_top import rem_pkg::*; #(
  parameter int unsigned MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [5:0]         in_replica_index,
  input  logic [15:0]        in_param_value,
  input  logic signed [31:0] in_energy,
  input  logic [15:0]        in_temperature,
  input  logic [15:0]        in_uniform_random,
  input  logic               in_iteration_parity,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_index,
  output logic [15:0]        out_param,
  output logic               out_swapped,
  output logic               out_error,
  output logic               out_last
);

  cfg_t cfg_r;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.replica_count  <= RC_RESET;
      cfg_r.gas_constant_q <= GAS_RESET;
      cfg_r.pairing_kind   <= KIND_VALID;
      cfg_r.sampling_kind  <= KIND_VALID;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REPLICA_COUNT: cfg_r.replica_count  <= cfg_wdata[6:0];
        CFG_GAS_CONSTANT:  cfg_r.gas_constant_q <= cfg_wdata;
        CFG_PAIRING_KIND:  cfg_r.pairing_kind   <= cfg_wdata[1:0];
        CFG_SAMPLING_KIND: cfg_r.sampling_kind  <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  rem_front #(.MAX_REPLICAS(MAX_REPLICAS)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_replica_index    (in_replica_index),
    .in_param_value      (in_param_value),
    .in_energy           (in_energy),
    .in_temperature      (in_temperature),
    .in_uniform_random   (in_uniform_random),
    .in_iteration_parity (in_iteration_parity),
    .in_last             (in_last),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_ready           (cmd_ready)
  );

  rem_back #(.MAX_REPLICAS(MAX_REPLICAS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_index   (out_index),
    .out_param   (out_param),
    .out_swapped (out_swapped),
    .out_error   (out_error),
    .out_last    (out_last)
  );

endmodule

// ----- design/rem_front.sv -----
// front end: accepts input words, classifies them and queues commands
// depends on rem_pkg
module rem_front import rem_pkg::*; #(
  parameter int unsigned MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [5:0]         in_replica_index,
  input  logic [15:0]        in_param_value,
  input  logic signed [31:0] in_energy,
  input  logic [15:0]        in_temperature,
  input  logic [15:0]        in_uniform_random,
  input  logic               in_iteration_parity,
  input  logic               in_last,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_ready
);

  cmd_t       fifo_r [FIFO_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.perm_wr  = ~in_op;
    cls.in_range = 32'(in_replica_index) < MAX_REPLICAS;
    cls.round    = in_op & in_last;
    cls.idx      = in_replica_index;
    cls.param    = in_param_value;
    cls.energy   = in_energy;
    cls.temp     = in_temperature;
    cls.rnd      = in_uniform_random;
    cls.parity   = in_iteration_parity;
  end

  assign in_ready  = count_r != 3'(FIFO_DEPTH);
  assign cmd_valid = count_r != 3'd0;
  assign cmd       = fifo_r[rd_ptr_r];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- design/rem_div.sv -----
// restoring divider, one quotient bit per cycle: (1000 << 52) / divisor
// depends on rem_pkg
module rem_div import rem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RT_W-1:0]  divisor,
  output logic             done,
  output logic [INV_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [5:0]       bit_r;
  logic [RT_W-1:0]  d_r;
  logic [RT_W-1:0]  rem_r, rem_nxt;
  logic [INV_W-1:0] q_r;
  logic [RT_W:0]    shifted;
  logic             ge;

  always_comb begin
    shifted = {rem_r, INV_NUM[bit_r]};
    ge      = shifted >= {1'b0, d_r};
    rem_nxt = ge ? RT_W'(shifted - {1'b0, d_r}) : shifted[RT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= '0;
      bit_r <= 6'(INV_W - 1);
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[INV_W-2:0], ge};
      bit_r <= bit_r - 6'd1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- design/rem_back.sv -----
// back end: sample stores, permutation table and the exchange round sequencer
// depends on rem_pkg and rem_div
module rem_back import rem_pkg::*; #(
  parameter int unsigned MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_index,
  output logic [15:0] out_param,
  output logic        out_swapped,
  output logic        out_error,
  output logic        out_last
);

  // slots above 63 cannot be addressed by a 6-bit index
  localparam int unsigned DEPTH = (MAX_REPLICAS < RES_LIMIT) ? MAX_REPLICAS : RES_LIMIT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t state_r, state_nxt;

  logic signed [31:0] energy_mem_r [DEPTH];
  logic [15:0]        temp_mem_r   [DEPTH];
  logic [15:0]        rnd_mem_r    [DEPTH];
  logic [15:0]        perm_mem_r   [DEPTH];
  logic [DEPTH-1:0]   pv_r;

  logic signed [31:0] ea_q_r, eb_q_r;
  logic [15:0]        ta_q_r, tb_q_r, ra_q_r, pa_q_r, pb_q_r;
  logic               pva_q_r, pvb_q_r;
  logic [AW-1:0]      pia_q_r, pib_q_r;

  logic [CNT_W-1:0]   n_r, cnt_r, pair_r;
  logic               bad_r, error_r;
  logic [RES_LIMIT-1:0] marks_r;
  logic [RT_W-1:0]    rta_r, rtb_r;
  logic [DMAG_W-1:0]  dmag_r;
  logic               deneg_r;
  logic [15:0]        rnd_r, perma_r, permb_r;
  logic [INV_W-1:0]   ia_r, ib_r, imag_r;
  logic               sat_r;
  logic [ACC_W-1:0]   acc_r;
  logic [5:0]         bit_r;
  logic [22:0]        y_r;
  logic [16:0]        tk_r;
  logic [23:0]        prod_r;
  logic [6:0]         nexp_r;

  logic               out_valid_r, out_swapped_r, out_error_r, out_last_r;
  logic [5:0]         out_index_r;
  logic [15:0]        out_param_r;

  // strobes
  logic               sample_we, perm_we, out_load, out_free, div_start, div_done;
  logic [AW-1:0]      addr_a, addr_b, perm_waddr;
  logic [15:0]        perm_wdata;
  logic [RT_W-1:0]    div_divisor;
  logic [INV_W-1:0]   div_q;

  // datapath comb
  logic [CNT_W-1:0]   n_clamp;
  logic               inv_neg, trivial, accept, last_entry;
  logic [INV_W-1:0]   imag_c;
  logic [ACC_W-1:0]   add_term, acc_sum, acc_nxt;
  logic               sat_nxt;
  logic [38:0]        y_full;
  logic [16:0]        tk_c, tk1_c, v_c, p_c;
  logic [32:0]        de;

  rem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (32'(cfg.replica_count) > DEPTH) begin
      n_clamp = CNT_W'(DEPTH);
    end else if (cfg.replica_count < 7'd2) begin
      n_clamp = CNT_W'(2);
    end else begin
      n_clamp = cfg.replica_count;
    end
    de         = {ea_q_r[31], ea_q_r} - {eb_q_r[31], eb_q_r};
    inv_neg    = ia_r < ib_r;
    imag_c     = inv_neg ? ib_r - ia_r : ia_r - ib_r;
    trivial    = (dmag_r == '0) || (imag_c == '0) || (deneg_r == inv_neg);
    // msb-first shift-add, clamped at the saturation limit
    add_term   = dmag_r[bit_r] ? imag_r[ACC_W-1:0] : '0;
    acc_sum    = {acc_r[ACC_W-2:0], 1'b0} + add_term;
    sat_nxt    = sat_r || (acc_sum > DELTA_LIMIT);
    acc_nxt    = sat_nxt ? DELTA_LIMIT : acc_sum;
    y_full     = acc_r[45:24] * LOG2E_Q16;
    tk_c       = pow2_neg({1'b0, y_r[15:12]});
    tk1_c      = pow2_neg({1'b0, y_r[15:12]} + 5'd1);
    v_c        = tk_r - {5'b0, prod_r[23:12]};
    p_c        = (nexp_r >= EXP_N_MAX) ? 17'd0 : (v_c >> nexp_r);
    accept     = {1'b0, rnd_r} < p_c;
    last_entry = cnt_r + CNT_W'(1) == n_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (cmd_valid && cmd.round) state_nxt = S_SCAN_RD;
      S_SCAN_RD:   state_nxt = S_SCAN_CHK;
      S_SCAN_CHK:  state_nxt = last_entry ? S_ROUND_GO : S_SCAN_RD;
      S_ROUND_GO:  state_nxt = (bad_r || !(pair_r + CNT_W'(1) < n_r)) ? S_EMIT_RD : S_PAIR_RD;
      S_PAIR_RD:   state_nxt = S_MUL;
      S_MUL:       state_nxt = S_DIVA_GO;
      S_DIVA_GO:   state_nxt = S_DIVA_WAIT;
      S_DIVA_WAIT: if (div_done) state_nxt = S_DIVB_GO;
      S_DIVB_GO:   state_nxt = S_DIVB_WAIT;
      S_DIVB_WAIT: if (div_done) state_nxt = S_DELTA;
      S_DELTA:     state_nxt = trivial ? S_SWAP_A : S_SMUL;
      S_SMUL:      if (bit_r == 6'd0) state_nxt = S_EXP1;
      S_EXP1:      state_nxt = S_EXP2;
      S_EXP2:      state_nxt = S_EXP3;
      S_EXP3:      state_nxt = accept ? S_SWAP_A : S_NEXT;
      S_SWAP_A:    state_nxt = S_SWAP_B;
      S_SWAP_B:    state_nxt = S_NEXT;
      S_NEXT:      state_nxt = (pair_r + CNT_W'(3) < n_r) ? S_PAIR_RD : S_EMIT_RD;
      S_EMIT_RD:   state_nxt = S_EMIT_WR;
      S_EMIT_WR:   if (out_free) state_nxt = last_entry ? S_IDLE : S_EMIT_RD;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready   = state_r == S_IDLE;
    sample_we   = 1'b0;
    perm_we     = 1'b0;
    perm_waddr  = AW'(pair_r);
    perm_wdata  = permb_r;
    div_start   = (state_r == S_DIVA_GO) || (state_r == S_DIVB_GO);
    div_divisor = (state_r == S_DIVB_GO) ? rtb_r : rta_r;
    out_free    = !out_valid_r || out_ready;
    out_load    = (state_r == S_EMIT_WR) && out_free;
    addr_a      = (state_r == S_PAIR_RD) ? AW'(pair_r) : AW'(cnt_r);
    addr_b      = AW'(pair_r + CNT_W'(1));
    unique case (state_r)
      S_IDLE: begin
        sample_we  = cmd_valid && !cmd.perm_wr && cmd.in_range;
        perm_we    = cmd_valid && cmd.perm_wr && cmd.in_range;
        perm_waddr = AW'(cmd.idx);
        perm_wdata = cmd.param;
      end
      S_SWAP_A: begin
        perm_we = 1'b1;
      end
      S_SWAP_B: begin
        perm_we    = 1'b1;
        perm_waddr = AW'(pair_r + CNT_W'(1));
        perm_wdata = perma_r;
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (sample_we) begin
      energy_mem_r[AW'(cmd.idx)] <= cmd.energy;
      temp_mem_r[AW'(cmd.idx)]   <= cmd.temp;
      rnd_mem_r[AW'(cmd.idx)]    <= cmd.rnd;
    end
    ea_q_r <= energy_mem_r[addr_a];
    eb_q_r <= energy_mem_r[addr_b];
    ta_q_r <= temp_mem_r[addr_a];
    tb_q_r <= temp_mem_r[addr_b];
    ra_q_r <= rnd_mem_r[addr_a];
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem_r[perm_waddr] <= perm_wdata;
    end
    pa_q_r  <= perm_mem_r[addr_a];
    pb_q_r  <= perm_mem_r[addr_b];
    pia_q_r <= addr_a;
    pib_q_r <= addr_b;
  end

  // unwritten permutation entries read as identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      pva_q_r <= 1'b0;
      pvb_q_r <= 1'b0;
    end else begin
      if (perm_we) begin
        pv_r[perm_waddr] <= 1'b1;
      end
      pva_q_r <= pv_r[addr_a];
      pvb_q_r <= pv_r[addr_b];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      marks_r     <= '0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && cmd_valid && cmd.round) begin
        marks_r <= '0;
      end
      if (state_r == S_ROUND_GO) begin
        error_r <= bad_r;
      end
      if (state_r == S_SWAP_A) begin
        marks_r[pair_r[5:0]]                  <= 1'b1;
        marks_r[6'(pair_r + CNT_W'(1))]       <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        n_r    <= n_clamp;
        cnt_r  <= '0;
        pair_r <= CNT_W'(cmd.parity);
        bad_r  <= (cfg.pairing_kind != KIND_VALID) || (cfg.sampling_kind != KIND_VALID)
                  || (cfg.gas_constant_q == 24'd0);
      end
      S_SCAN_CHK: begin
        if (ta_q_r == 16'd0) begin
          bad_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
      S_ROUND_GO: begin
        cnt_r <= '0;
      end
      S_MUL: begin
        rta_r   <= cfg.gas_constant_q * ta_q_r;
        rtb_r   <= cfg.gas_constant_q * tb_q_r;
        deneg_r <= de[32];
        dmag_r  <= de[32] ? DMAG_W'(-de) : de;
        rnd_r   <= ra_q_r;
        perma_r <= pva_q_r ? pa_q_r : 16'(pia_q_r);
        permb_r <= pvb_q_r ? pb_q_r : 16'(pib_q_r);
      end
      S_DIVA_WAIT: begin
        if (div_done) begin
          ia_r <= div_q;
        end
      end
      S_DIVB_WAIT: begin
        if (div_done) begin
          ib_r <= div_q;
        end
      end
      S_DELTA: begin
        imag_r <= imag_c;
        sat_r  <= imag_c > {{(INV_W-ACC_W){1'b0}}, DELTA_LIMIT};
        acc_r  <= '0;
        bit_r  <= 6'(DMAG_W - 1);
      end
      S_SMUL: begin
        sat_r <= sat_nxt;
        acc_r <= acc_nxt;
        bit_r <= bit_r - 6'd1;
      end
      S_EXP1: begin
        y_r <= y_full[38:16];
      end
      S_EXP2: begin
        tk_r   <= tk_c;
        // neighbor table step is below 4096, so the low 12 bits hold it exactly
        prod_r <= 12'(tk_c[11:0] - tk1_c[11:0]) * y_r[11:0];
        nexp_r <= y_r[22:16];
      end
      S_NEXT: begin
        pair_r <= pair_r + CNT_W'(2);
      end
      S_EMIT_WR: begin
        if (out_free) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r   <= cnt_r[5:0];
      out_param_r   <= pva_q_r ? pa_q_r : 16'(pia_q_r);
      out_swapped_r <= marks_r[cnt_r[5:0]];
      out_error_r   <= error_r;
      out_last_r    <= last_entry;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_param   = out_param_r;
  assign out_swapped = out_swapped_r;
  assign out_error   = out_error_r;
  assign out_last    = out_last_r;

  a_err_nosw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_WR && error_r) |-> (marks_r == '0))
    else $error("swap marks set in a failed round");

  a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP_A) |-> (pair_r + CNT_W'(1) < n_r))
    else $error("swap outside the round");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SMUL) |-> (acc_r <= DELTA_LIMIT))
    else $error("exponent accumulator above limit");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_WR && !out_free) |=> (state_r == S_EMIT_WR && $stable(cnt_r)))
    else $error("emission advanced while output stalled");

endmodule

// ----- bench/tb_replica_exchange_metropolis_top.sv -----
// self-checking bench for replica_exchange_metropolis_top: directed and random exchange rounds
// with random idling on both channels; depends on rem_pkg and the design files
module tb_replica_exchange_metropolis_top;
  import rem_pkg::*;

  typedef struct {
    logic [5:0]  index;
    logic [15:0] param;
    logic        swapped;
    logic        error;
    logic        last;
  } perm_word_t;

  localparam logic OP_PERM_WRITE = 1'b0;
  localparam logic OP_SAMPLE     = 1'b1;
  localparam int   SLOTS         = 64;
  localparam int   MAX_GAP       = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_REPLICA_COUNT;
  logic [23:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_PERM_WRITE;
  logic [5:0]         in_replica_index = '0;
  logic [15:0]        in_param_value = '0;
  logic signed [31:0] in_energy = '0;
  logic [15:0]        in_temperature = '0;
  logic [15:0]        in_uniform_random = '0;
  logic               in_iteration_parity = 1'b0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         out_index;
  logic [15:0]        out_param;
  logic               out_swapped;
  logic               out_error;
  logic               out_last;

  replica_exchange_metropolis_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_replica_index(in_replica_index), .in_param_value(in_param_value),
    .in_energy(in_energy), .in_temperature(in_temperature),
    .in_uniform_random(in_uniform_random), .in_iteration_parity(in_iteration_parity),
    .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_param(out_param), .out_swapped(out_swapped), .out_error(out_error),
    .out_last(out_last)
  );

  // exchange model state
  logic signed [31:0] energy_mem [SLOTS];
  logic [15:0]        temp_mem [SLOTS];
  logic [15:0]        rand_mem [SLOTS];
  logic [15:0]        perm_mem [SLOTS];
  logic               swap_mem [SLOTS];
  logic               err_flag;
  logic [6:0]         rc_reg;
  logic [23:0]        gas_reg;
  logic [1:0]         pair_reg;
  logic [1:0]         samp_reg;

  perm_word_t pending_words[$];
  int unsigned exp2_tab [17] = '{65536, 62757, 60097, 57549, 55110, 52773, 50535, 48393,
                                 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  int  mismatches = 0;
  int  words_sent = 0;
  int  rounds_run = 0;
  int  words_checked = 0;
  bit  no_idle = 1'b0;

  initial forever #10 clk = ~clk;

  initial begin
    #50_000_000;
    $display("** replica_exchange_metropolis_top: FAILED **");
    $finish;
  end

  function automatic longint unsigned inv_rt(logic [15:0] t);
    longint unsigned rt;
    rt = longint'(gas_reg) * longint'(t);
    return (rt == 0) ? 0 : ((64'd1000 << 52) / rt);
  endfunction

  // q1.16 value of exp(-m), m in q.40
  function automatic int unsigned exp_neg_q16(longint unsigned m);
    longint unsigned m16, y, n;
    int unsigned f, k, r, v;
    m16 = m >> 24;
    y = (m16 * 64'd94548) >> 16;
    n = y >> 16;
    f = int'(y & 64'hFFFF);
    k = f >> 12;
    r = f & 12'hFFF;
    v = exp2_tab[k] - (((exp2_tab[k] - exp2_tab[k+1]) * r) >> 12);
    return (n >= 17) ? 0 : (v >> n);
  endfunction

  function automatic bit pair_accepts(int a, int b);
    longint signed de;
    longint unsigned ia, ib, dmag, imag, m, lim;
    bit de_neg, inv_neg;
    lim = 64'd32 << 40;
    de = longint'(energy_mem[a]) - longint'(energy_mem[b]);
    ia = inv_rt(temp_mem[a]);
    ib = inv_rt(temp_mem[b]);
    de_neg = de < 0;
    dmag = de_neg ? longint'(-de) : longint'(de);
    inv_neg = ia < ib;
    imag = inv_neg ? ib - ia : ia - ib;
    if (dmag == 0 || imag == 0 || de_neg == inv_neg) return 1'b1;
    m = (dmag > lim / imag) ? lim : dmag * imag;
    if (m > lim) m = lim;
    return int'(rand_mem[a]) < exp_neg_q16(m);
  endfunction

  function automatic int round_size();
    int n;
    n = rc_reg;
    if (n > SLOTS) n = SLOTS;
    if (n < 2) n = 2;
    return n;
  endfunction

  // model update for one accepted word; queues the emitted permutation on a round
  function automatic void exchange_model(logic op, logic [5:0] idx, logic [15:0] param,
      logic signed [31:0] en, logic [15:0] t, logic [15:0] rnd, logic par, logic lst);
    int n, i;
    bit bad;
    logic [15:0] tmp;
    perm_word_t w;
    if (op == OP_PERM_WRITE) begin
      perm_mem[idx] = param;
      return;
    end
    energy_mem[idx] = en;
    temp_mem[idx] = t;
    rand_mem[idx] = rnd;
    if (!lst) return;
    n = round_size();
    rounds_run++;
    for (i = 0; i < SLOTS; i++) swap_mem[i] = 1'b0;
    bad = (pair_reg != KIND_VALID) || (samp_reg != KIND_VALID);
    for (i = 0; i < n; i++)
      if (gas_reg == 0 || temp_mem[i] == 0) bad = 1'b1;
    err_flag = bad;
    if (!bad) begin
      for (i = par; i + 1 < n; i += 2) begin
        if (pair_accepts(i, i + 1)) begin
          tmp = perm_mem[i];
          perm_mem[i] = perm_mem[i+1];
          perm_mem[i+1] = tmp;
          swap_mem[i] = 1'b1;
          swap_mem[i+1] = 1'b1;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      w.index = i[5:0];
      w.param = perm_mem[i];
      w.swapped = swap_mem[i];
      w.error = err_flag;
      w.last = (i + 1 == n);
      pending_words = {pending_words, w};
    end
  endfunction

  task automatic send_word(logic op, logic [5:0] idx, logic [15:0] param,
      logic signed [31:0] en, logic [15:0] t, logic [15:0] rnd, logic par, logic lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_replica_index <= idx;
    in_param_value <= param;
    in_energy <= en;
    in_temperature <= t;
    in_uniform_random <= rnd;
    in_iteration_parity <= par;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    exchange_model(op, idx, param, en, t, rnd, par, lst);
  endtask

  task automatic send_sample(int s, logic signed [31:0] en, logic [15:0] t,
      logic [15:0] rnd, logic par, logic lst);
    send_word(OP_SAMPLE, s[5:0], 16'($urandom), en, t, rnd, par, lst);
  endtask

  // wait for the block to drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [23:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REPLICA_COUNT: rc_reg = value[6:0];
      CFG_GAS_CONSTANT:  gas_reg = value;
      CFG_PAIRING_KIND:  pair_reg = value[1:0];
      CFG_SAMPLING_KIND: samp_reg = value[1:0];
    endcase
  endtask

  function automatic logic signed [31:0] pick_energy(int mode);
    // near energies give exponents inside the table, far ones saturate
    if (mode == 0) return 32'($urandom);
    return 32'($urandom_range(0, 4096 * 8)) - 32'sd16384 - 32'sd81920000;
  endfunction

  function automatic logic [15:0] pick_temp(bit allow_zero);
    if (allow_zero && $urandom_range(0, 24) == 0) return 16'd0;
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(4800, 6400));
  endfunction

  // output side: stall per word, then compare with the oldest expectation
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    perm_word_t e;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: index %0d param %0d", out_index, out_param);
      end else begin
        e = pending_words.pop_front();
        if (out_index !== e.index || out_param !== e.param || out_swapped !== e.swapped ||
            out_error !== e.error || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d param %0d sw %0b err %0b last %0b, got %0d %0d %0b %0b %0b",
                     e.index, e.param, e.swapped, e.error, e.last,
                     out_index, out_param, out_swapped, out_error, out_last);
        end
      end
    end
  end

  task automatic test_fill_slots();
    for (int s = 0; s < SLOTS; s++)
      send_sample(s, pick_energy(1), pick_temp(0), 16'($urandom), 1'b0, 1'b0);
  endtask

  task automatic test_directed();
    // default pair of two replicas
    send_sample(0, 32'sh8000_0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_sample(1, 32'sh7FFF_FFFF, 16'd1, 16'hFFFF, 1'b0, 1'b1);
    send_sample(1, 32'sh7FFF_FFFF, 16'd1, 16'h0000, 1'b0, 1'b1);
    send_sample(0, 32'sd4096, 16'd4800, 16'h0000, 1'b0, 1'b0);
    send_sample(1, 32'sd0, 16'd4816, 16'hFFFF, 1'b0, 1'b1);
    send_sample(0, 32'sd0, 16'd4800, 16'h8000, 1'b0, 1'b1);
    // parity 1 on two replicas leaves no pair
    send_sample(1, 32'sd5, 16'd4800, 16'h1234, 1'b1, 1'b1);
    // zero temperature flags the round
    send_sample(1, 32'sd5, 16'd0, 16'h1234, 1'b0, 1'b1);
    send_sample(1, 32'sd5, 16'd4800, 16'h1234, 1'b0, 1'b1);
    // permutation writes, two with a last mark that must not run a round
    send_word(OP_PERM_WRITE, 6'd0, 16'hFFFF, '0, '0, '0, 1'b0, 1'b0);
    send_word(OP_PERM_WRITE, 6'd1, 16'h0000, '0, '0, '0, 1'b1, 1'b1);
    send_word(OP_PERM_WRITE, 6'd63, 16'hA5A5, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_sample(63, 32'sh8000_0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_sample(0, -32'sd4096, 16'd4800, 16'h0001, 1'b0, 1'b1);
    settle();
  endtask

  task automatic run_round(int count, bit allow_zero);
    int n, k, s;
    bit par;
    n = round_size();
    k = $urandom_range(1, (count < n) ? count : n);
    par = $urandom_range(0, 1);
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(0, 5) == 0)
        send_word(OP_PERM_WRITE, 6'($urandom_range(0, SLOTS - 1)), 16'($urandom),
                  32'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      s = $urandom_range(0, n - 1);
      send_sample(s, pick_energy($urandom_range(0, 2) == 0 ? 0 : 1), pick_temp(allow_zero),
                  16'($urandom), par, (j == k - 1));
    end
  endtask

  task automatic test_config_sweep();
    logic [6:0]  counts [6] = '{7'd0, 7'd1, 7'd5, 7'd64, 7'd127, 7'd9};
    logic [23:0] gases  [4] = '{24'd1, 24'hFFFFFF, 24'd0, GAS_RESET};
    for (int i = 0; i < 6; i++) begin
      write_cfg(CFG_REPLICA_COUNT, {17'($urandom), counts[i]});
      run_round(3, 1'b0);
      settle();
    end
    for (int i = 0; i < 4; i++) begin
      write_cfg(CFG_GAS_CONSTANT, gases[i]);
      run_round(3, 1'b0);
      settle();
    end
    for (int kind = 0; kind < 4; kind++) begin
      write_cfg(CFG_PAIRING_KIND, 24'(kind));
      write_cfg(CFG_SAMPLING_KIND, 24'((kind + 1) % 4));
      run_round(2, 1'b0);
      settle();
    end
    write_cfg(CFG_PAIRING_KIND, 24'(KIND_VALID));
    write_cfg(CFG_SAMPLING_KIND, 24'(KIND_VALID));
  endtask

  task automatic test_random_rounds();
    int phase;
    phase = 0;
    while (words_sent < 280) begin
      if (phase % 4 == 0) begin
        settle();
        no_idle = (phase % 8 == 4);
        write_cfg(CFG_REPLICA_COUNT, 24'($urandom_range(2, 12)));
        if ($urandom_range(0, 2) == 0) write_cfg(CFG_GAS_CONSTANT, 24'($urandom_range(1, 24'hFFFFFF)));
        else write_cfg(CFG_GAS_CONSTANT, GAS_RESET);
      end
      run_round(6, 1'b1);
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rc_reg = RC_RESET;
    gas_reg = GAS_RESET;
    pair_reg = KIND_VALID;
    samp_reg = KIND_VALID;
    err_flag = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      perm_mem[i] = 16'(i);
      swap_mem[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_slots();
    test_directed();
    test_config_sweep();
    test_random_rounds();
    settle();
    repeat (200) @(posedge clk);
    $display("sent %0d words over %0d exchange rounds, checked %0d permutation words",
             words_sent, rounds_run, words_checked);
    $display("mismatches: %0d, words still expected: %0d", mismatches, pending_words.size());
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("** replica_exchange_metropolis_top: PASSED **");
    end else begin
      $display("** replica_exchange_metropolis_top: FAILED **");
    end
    $finish;
  end

endmodule
